### rtl/core/encoder_route_segment_recorder_top_defines.svh
// Assertion helpers shared by the RTL of the route segment recorder.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef ENCODER_ROUTE_SEGMENT_RECORDER_TOP_DEFINES_SVH
`define ENCODER_ROUTE_SEGMENT_RECORDER_TOP_DEFINES_SVH

// Same-cycle implication
`define ERSR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ERSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ersr_pkg.sv
`timescale 1ns / 1ps

package ersr_pkg;

    localparam int SEGMENTS = 32;
    localparam int IDX_W    = $clog2(SEGMENTS + 1);

    localparam logic [7:0] STEP_RESET = 8'd10;
    localparam logic [3:0] DIGIT_MAX  = 4'd9;
    localparam logic [7:0] METER_MAX  = 8'd255;
    localparam logic [7:0] DEG_MAX    = 8'd180;
    localparam logic [7:0] DEG_STEP   = 8'd4;

    localparam logic KIND_PULSE = 1'b0;
    localparam logic KIND_START = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_PPCM = 1'b0;
    localparam logic REG_PPFD = 1'b1;

    localparam logic [1:0] DIR_FWD   = 2'd0;
    localparam logic [1:0] DIR_BWD   = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    typedef struct packed {
        logic kind;
        logic left_motor_dir;
        logic right_motor_dir;
    } t_in_item;

    typedef struct packed {
        logic [4:0] seg_index;
        logic [1:0] seg_dir;
        logic [7:0] seg_meters;
        logic [3:0] seg_decimeters;
        logic [3:0] seg_centimeters;
        logic [7:0] seg_degrees;
        logic [7:0] seg_pulses;
        logic       table_full;
    } t_out_item;

endpackage

### rtl/core/encoder_route_segment_recorder_top.sv
`timescale 1ns / 1ps
// Route segment recorder: takes one encoder item per cycle while o_in_stall is low. When a change
// between straight and turn closes a segment, that segment is loaded into the output register if
// that register is empty or being accepted. The state update is registered digit carry/borrow
// logic. The output side has an output register plus one skid entry. A segment that closes while
// the output register still holds an unaccepted result goes to the skid entry. o_in_stall is high
// only while the skid entry is occupied. It falls in the cycle after the consumer accepts the held
// result. Step registers are written over the APB port at byte addresses 0 and 4. The user must
// write them only while the block is idle; the block itself does not enforce this.
`include "encoder_route_segment_recorder_top_defines.svh"

module encoder_route_segment_recorder_top import ersr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]       r_ppcm, r_ppfd;
    logic [1:0]       r_cur_dir, n_cur_dir;
    logic             r_armed, n_armed;
    logic [7:0]       r_pulse, n_pulse;
    logic [3:0]       r_centi, n_centi;
    logic [3:0]       r_deci, n_deci;
    logic [7:0]       r_meter, n_meter;
    logic [7:0]       r_degree, n_degree;
    logic [IDX_W-1:0] r_next_index, n_next_index;

    logic             r_out_valid, n_out_valid;
    logic             r_skid_valid, n_skid_valid;
    t_out_item        r_out_item, r_skid_item;

    logic             in_acc, out_take, cfg_wr;
    logic [1:0]       in_dir;
    logic [7:0]       step_cm, step_deg, pulse_inc;
    logic             full;
    logic [IDX_W-1:0] idx;
    logic             res_valid;
    t_out_item        res_item;
    logic             load_out_res, load_out_skid, load_skid;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = {24'd0, (paddr[2] == REG_PPFD) ? r_ppfd : r_ppcm};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppcm <= STEP_RESET;
            r_ppfd <= STEP_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_PPCM) begin
                r_ppcm <= pwdata[7:0];
            end else begin
                r_ppfd <= pwdata[7:0];
            end
        end
    end

    // ---------------- segment update ----------------
    assign o_in_stall = r_skid_valid;
    assign in_acc     = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;

    assign step_cm   = (r_ppcm == 8'd0) ? 8'd1 : r_ppcm;
    assign step_deg  = (r_ppfd == 8'd0) ? 8'd1 : r_ppfd;
    assign pulse_inc = r_pulse + 8'd1;

    always_comb begin
        case ({i_in_item.left_motor_dir, i_in_item.right_motor_dir})
            2'b10:   in_dir = DIR_FWD;
            2'b01:   in_dir = DIR_BWD;
            2'b00:   in_dir = DIR_RIGHT;
            default: in_dir = DIR_LEFT;
        endcase
    end

    assign full = (r_next_index >= IDX_W'(SEGMENTS));
    assign idx  = full ? IDX_W'(SEGMENTS - 1) : r_next_index;

    always_comb begin
        res_item.seg_index       = 5'(idx);
        res_item.seg_dir         = r_cur_dir;
        res_item.seg_meters      = r_meter;
        res_item.seg_decimeters  = r_deci;
        res_item.seg_centimeters = r_centi;
        res_item.seg_degrees     = r_degree;
        res_item.seg_pulses      = r_pulse;
        res_item.table_full      = full;
    end

    always_comb begin
        n_cur_dir    = r_cur_dir;
        n_armed      = r_armed;
        n_pulse      = r_pulse;
        n_centi      = r_centi;
        n_deci       = r_deci;
        n_meter      = r_meter;
        n_degree     = r_degree;
        n_next_index = r_next_index;
        res_valid    = 1'b0;

        if (in_acc) begin
            if (i_in_item.kind == KIND_START) begin
                n_armed = 1'b1;
            end else if (r_armed) begin
                n_armed      = 1'b0;
                n_next_index = '0;
                n_cur_dir    = in_dir;
                n_pulse      = 8'd1;
                n_centi      = 4'd0;
                n_deci       = 4'd0;
                n_meter      = 8'd0;
                n_degree     = 8'd0;
            end else if (!in_dir[1] && !r_cur_dir[1]) begin
                // straight: pulses -> cm -> dm -> m
                if (in_dir == r_cur_dir) begin
                    if (pulse_inc >= step_cm) begin
                        n_pulse = 8'd0;
                        if (r_centi >= DIGIT_MAX) begin
                            n_centi = 4'd0;
                            if (r_deci >= DIGIT_MAX) begin
                                n_deci = 4'd0;
                                if (r_meter != METER_MAX) n_meter = r_meter + 8'd1;
                            end else begin
                                n_deci = r_deci + 4'd1;
                            end
                        end else begin
                            n_centi = r_centi + 4'd1;
                        end
                    end else begin
                        n_pulse = pulse_inc;
                    end
                end else if (r_pulse != 8'd0) begin
                    n_pulse = r_pulse - 8'd1;
                end else if (r_centi != 4'd0) begin
                    n_pulse = step_cm - 8'd1;
                    n_centi = r_centi - 4'd1;
                end else if (r_deci != 4'd0) begin
                    n_pulse = step_cm - 8'd1;
                    n_centi = DIGIT_MAX;
                    n_deci  = r_deci - 4'd1;
                end else if (r_meter != 8'd0) begin
                    n_pulse = step_cm - 8'd1;
                    n_centi = DIGIT_MAX;
                    n_deci  = DIGIT_MAX;
                    n_meter = r_meter - 8'd1;
                end else begin
                    // backed past the start: restart the other way
                    n_cur_dir = (r_cur_dir == DIR_FWD) ? DIR_BWD : DIR_FWD;
                    n_pulse   = 8'd1;
                end
            end else if (in_dir[1] && r_cur_dir[1]) begin
                // turn: pulses -> 4 degree steps
                if (in_dir == r_cur_dir) begin
                    n_pulse = pulse_inc;
                    if (pulse_inc >= step_deg) begin
                        n_pulse = 8'd0;
                        if (r_degree < DEG_MAX) n_degree = r_degree + DEG_STEP;
                    end
                    if (n_degree >= DEG_MAX) begin
                        n_degree  = DEG_MAX;
                        n_cur_dir = (r_cur_dir == DIR_LEFT) ? DIR_RIGHT : DIR_LEFT;
                    end
                end else if (r_pulse != 8'd0) begin
                    n_pulse = r_pulse - 8'd1;
                end else if (r_degree >= DEG_STEP) begin
                    n_pulse  = step_deg - 8'd1;
                    n_degree = r_degree - DEG_STEP;
                end else begin
                    n_cur_dir = (r_cur_dir == DIR_LEFT) ? DIR_RIGHT : DIR_LEFT;
                    n_pulse   = 8'd1;
                end
            end else begin
                // kind change closes the segment
                res_valid = 1'b1;
                if (!full) n_next_index = r_next_index + IDX_W'(1);
                n_cur_dir = in_dir;
                n_pulse   = 8'd1;
                n_centi   = 4'd0;
                n_deci    = 4'd0;
                n_meter   = 8'd0;
                n_degree  = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_dir    <= DIR_FWD;
            r_armed      <= 1'b1;
            r_pulse      <= 8'd0;
            r_centi      <= 4'd0;
            r_deci       <= 4'd0;
            r_meter      <= 8'd0;
            r_degree     <= 8'd0;
            r_next_index <= '0;
        end else begin
            r_cur_dir    <= n_cur_dir;
            r_armed      <= n_armed;
            r_pulse      <= n_pulse;
            r_centi      <= n_centi;
            r_deci       <= n_deci;
            r_meter      <= n_meter;
            r_degree     <= n_degree;
            r_next_index <= n_next_index;
        end
    end

    // ---------------- output register + skid ----------------
    always_comb begin
        n_out_valid   = r_out_valid;
        n_skid_valid  = r_skid_valid;
        load_out_res  = 1'b0;
        load_out_skid = 1'b0;
        load_skid     = 1'b0;
        if (r_skid_valid) begin
            if (out_take) begin
                n_skid_valid  = 1'b0;
                load_out_skid = 1'b1;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_take) begin
                load_out_res = 1'b1;
                n_out_valid  = 1'b1;
            end else begin
                load_skid    = 1'b1;
                n_skid_valid = 1'b1;
            end
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out_res) begin
            r_out_item <= res_item;
        end else if (load_out_skid) begin
            r_out_item <= r_skid_item;
        end
        if (load_skid) begin
            r_skid_item <= res_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // ---------------- assertions ----------------
    `ERSR_ASSERT_IMP(a_skid_behind_out, r_skid_valid, r_out_valid,
        "skid entry holds an item while the output register is empty")
    `ERSR_ASSERT_IMP(a_digits_decimal, 1'b1, (r_centi <= DIGIT_MAX) && (r_deci <= DIGIT_MAX),
        "distance digit out of decimal range")
    `ERSR_ASSERT_IMP(a_kind_fields, 1'b1,
        (r_cur_dir[1] && r_meter == 8'd0 && r_deci == 4'd0 && r_centi == 4'd0
         && r_degree <= DEG_MAX) || (!r_cur_dir[1] && r_degree == 8'd0),
        "segment holds fields of the wrong kind")
    `ERSR_ASSERT_IMP(a_index_bound, 1'b1, r_next_index <= IDX_W'(SEGMENTS),
        "segment index ran past the table")
    `ERSR_ASSERT_NEXT(a_start_arms, in_acc && i_in_item.kind == KIND_START, r_armed,
        "start item did not re-arm learning")

endmodule
